@@ rtl/core/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// bss_pkg: shared definitions for the byte substring search
// types, register indexes and default sizes used by the cell row and the top
// ----------------------------------------------------------------------------
package bss_pkg;

  // default sizes
  localparam int unsigned     MaxNeedleDef   = 32;
  localparam longint unsigned MaxHaystackDef = 65536;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenW     = 6;

  localparam logic [CfgIdxW-1:0] REG_NEEDLE_LEN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NEEDLE_A   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NEEDLE_B   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NEEDLE_C   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NEEDLE_D   = 3'd4;

  // all needle bytes, byte j at bits 8j upward across the four words
  typedef logic [3:0][CfgDataW-1:0] needle_t;

  // control handed to every cell of the row
  typedef struct packed {
    logic            shift;
    logic [LenW-1:0] len;
  } cell_ctrl_t;

endpackage

@@ rtl/core/bss_cell.sv @@
// ----------------------------------------------------------------------------
// bss_cell: one window byte of the substring search
// holds one haystack byte, passes it on to the next cell on each shift and
// checks the byte it is about to take against its aligned needle byte
// ----------------------------------------------------------------------------
module bss_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bss_pkg::cell_ctrl_t ctrl_i,
  input  bss_pkg::needle_t    needle_i,
  input  logic [7:0]          byte_i,
  output logic [7:0]          byte_o,
  output logic                eq_o
);
  import bss_pkg::*;

  logic [7:0]      byte_q;
  logic [LenW-1:0] sel;
  logic [7:0]      needle_byte;
  logic            in_use;

  // needle byte aligned to this window position: needle[len-1-idx]
  assign in_use      = LenW'(IDX) < ctrl_i.len;
  assign sel         = ctrl_i.len - LenW'(IDX) - LenW'(1);
  assign needle_byte = needle_i[sel[4:3]][{sel[2:0], 3'b000} +: 8];

  // compare on the incoming byte, positions beyond the needle always agree
  assign eq_o = !in_use || (byte_i == needle_byte);

  // window byte, shifted along the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

@@ rtl/core/bss_cell_row.sv @@
// ----------------------------------------------------------------------------
// bss_cell_row: sliding window of compare cells
// chains the cells newest first and combines their compare flags
// ----------------------------------------------------------------------------
module bss_cell_row #(
  parameter int unsigned MAX_NEEDLE = bss_pkg::MaxNeedleDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bss_pkg::cell_ctrl_t ctrl_i,
  input  bss_pkg::needle_t    needle_i,
  input  logic [7:0]          data_i,
  output logic                all_eq_o
);
  import bss_pkg::*;

  logic [MAX_NEEDLE-1:0][7:0] chain_in;
  logic [MAX_NEEDLE-1:0][7:0] chain_out;
  logic [MAX_NEEDLE-1:0]      eq;

  // newest byte enters cell zero, each cell feeds the next
  assign chain_in[0] = data_i;
  for (genvar k = 1; k < MAX_NEEDLE; k++) begin : g_link
    assign chain_in[k] = chain_out[k-1];
  end

  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
    bss_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_i),
      .needle_i (needle_i),
      .byte_i   (chain_in[k]),
      .byte_o   (chain_out[k]),
      .eq_o     (eq[k])
    );
  end

  // whole needle agrees with the window after this shift
  assign all_eq_o = &eq;

endmodule

@@ rtl/core/byte_substring_search.sv @@
// ----------------------------------------------------------------------------
// byte_substring_search: streaming first-occurrence substring search
// haystack bytes in, one answer per haystack out
// ----------------------------------------------------------------------------
// Takes one haystack byte per cycle unless stalled; gives at most one result
// beat per haystack: found with the start offset of the first match, or not
// found on the byte marked last (truncated set if bytes beyond MAX_HAYSTACK
// were dropped). The last MAX_NEEDLE bytes sit in a row of cells that compare
// all positions against the needle as a byte is accepted; the result is in
// the output register in the cycle after its byte. Input ready only drops
// while a result is held and not taken. Needle registers are to be written
// through the configuration port only while the block is idle; the block does
// not enforce this. A needle length above MAX_NEEDLE counts as MAX_NEEDLE.
// ----------------------------------------------------------------------------
module byte_substring_search #(
  parameter int unsigned     MAX_NEEDLE   = bss_pkg::MaxNeedleDef,
  parameter longint unsigned MAX_HAYSTACK = bss_pkg::MaxHaystackDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [bss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bss_pkg::CfgDataW-1:0] cfg_data_i,
  // haystack bytes
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [15:0]                  match_offset_o,
  output logic                         truncated_o
);
  import bss_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_HAYSTACK + 1);
  localparam int unsigned OffW = (CntW > 16) ? CntW : 16;

  logic [LenW-1:0] needle_len_q;
  needle_t         needle_q;
  logic [LenW-1:0] len;

  logic [CntW-1:0] count_q, count_d, count_inc;
  logic            answered_q, answered_d;
  logic            overflowed_q, overflowed_d;

  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;
  logic [15:0]     offset_q, offset_d;
  logic            trunc_q, trunc_d;

  logic            in_acc;
  logic            room;
  logic            all_eq;
  logic            res_valid;
  logic [OffW-1:0] diff;
  cell_ctrl_t      ctrl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_len_q <= '0;
      needle_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NEEDLE_LEN: needle_len_q <= cfg_data_i[LenW-1:0];
        REG_NEEDLE_A:   needle_q[0]  <= cfg_data_i;
        REG_NEEDLE_B:   needle_q[1]  <= cfg_data_i;
        REG_NEEDLE_C:   needle_q[2]  <= cfg_data_i;
        REG_NEEDLE_D:   needle_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective needle length
  assign len = (needle_len_q > LenW'(MAX_NEEDLE)) ? LenW'(MAX_NEEDLE) : needle_len_q;

  // handshake: a result register that is empty or being emptied takes a beat
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign room       = count_q < CntW'(MAX_HAYSTACK);
  assign count_inc  = count_q + CntW'(1);

  assign ctrl = '{shift: in_acc && !answered_q && room, len: len};

  bss_cell_row #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .needle_i (needle_q),
    .data_i   (data_byte_i),
    .all_eq_o (all_eq)
  );

  assign diff = OffW'(count_inc) - OffW'(len);

  // stream state and result of the accepted beat
  always_comb begin
    count_d      = count_q;
    answered_d   = answered_q;
    overflowed_d = overflowed_q;
    res_valid    = 1'b0;
    found_d      = found_q;
    offset_d     = offset_q;
    trunc_d      = trunc_q;
    if (in_acc) begin
      if (!answered_q) begin
        if (room) begin
          count_d = count_inc;
          if (len == '0) begin
            answered_d = 1'b1;
            res_valid  = 1'b1;
            found_d    = 1'b1;
            offset_d   = '0;
            trunc_d    = 1'b0;
          end else if ((OffW'(count_inc) >= OffW'(len)) && all_eq) begin
            answered_d = 1'b1;
            res_valid  = 1'b1;
            found_d    = 1'b1;
            offset_d   = diff[15:0];
            trunc_d    = 1'b0;
          end
        end else begin
          overflowed_d = 1'b1;
        end
        // not found by the end of the haystack
        if (last_byte_i && !answered_d) begin
          res_valid = 1'b1;
          found_d   = 1'b0;
          offset_d  = '0;
          trunc_d   = overflowed_d;
        end
      end
      // end of haystack clears the stream state
      if (last_byte_i) begin
        count_d      = '0;
        answered_d   = 1'b0;
        overflowed_d = 1'b0;
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      answered_q   <= 1'b0;
      overflowed_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      answered_q   <= answered_d;
      overflowed_q <= overflowed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      found_q  <= found_d;
      offset_q <= offset_d;
      trunc_q  <= trunc_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;
  assign truncated_o    = trunc_q;

  // a match never comes with dropped bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !truncated_o)
    else $error("found beat carries truncated flag");

  // the byte counter saturates at the haystack limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_HAYSTACK))
    else $error("byte counter beyond limit");

  // dropping bytes only happens once the counter is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflowed_q |-> count_q == CntW'(MAX_HAYSTACK))
    else $error("overflow flagged below limit");

  // the last beat of a haystack leaves a clean stream state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> !answered_q && !overflowed_q && count_q == '0)
    else $error("stream state not cleared after last beat");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result register");

endmodule

@@ verif/byte_substring_search_tb.sv @@
// ----------------------------------------------------------------------------
// byte_substring_search_tb: self-checking bench for the byte substring search
// ----------------------------------------------------------------------------
// Streams haystacks into the block and checks every result beat against a
// local scan that keeps its own window, byte count and needle copy. Directed
// haystacks cover the empty needle, a match on the last byte, short
// haystacks, bytes after a match, spare register indexes and a needle change
// in the middle of a haystack. Random phases follow with many needle
// settings and a back-pressure burst that fills the output and stalls input.
// ----------------------------------------------------------------------------
module byte_substring_search_tb;
  import bss_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned RxHoldCycles = 80;
  localparam int unsigned MaxReported  = 10;
  localparam logic [CfgIdxW-1:0] RegSpareLo = REG_NEEDLE_D + 3'd1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hay_beat_t;

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic        truncated;
  } answer_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block ports
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [7:0]          data_byte = '0;
  logic                last_byte = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                res_found;
  logic [15:0]         res_offset;
  logic                res_truncated;

  // stimulus and expected results
  hay_beat_t hay_pending [$];
  answer_t   answers_due [$];
  int unsigned src_idle_pct  = 35;
  int unsigned sink_idle_pct = 35;
  int unsigned rx_hold_reqs  = 0;
  int unsigned rx_hold_served = 0;
  int unsigned rx_hold_left  = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;

  // local copy of the needle and of the scan state
  logic [LenW-1:0] pat_len   = '0;
  needle_t         pat_words = '0;
  logic [7:0]      hist [MaxNeedleDef];
  logic [16:0]     seen_cnt  = '0;
  logic            hit_done  = 1'b0;
  logic            dropped   = 1'b0;

  byte_substring_search dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .found_o        (res_found),
    .match_offset_o (res_offset),
    .truncated_o    (res_truncated)
  );

  // 10 unit clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] pat_byte(input int unsigned j);
    return pat_words[2'(j >> 3)][{3'(j), 3'b000} +: 8];
  endfunction

  function automatic int unsigned eff_len();
    return (pat_len > MaxNeedleDef) ? MaxNeedleDef : int'(pat_len);
  endfunction

  // scan one accepted byte, returns 1 when it yields a result beat
  function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                   output answer_t ans);
    int unsigned len;
    int unsigned k;
    bit hit;
    bit same;
    len  = eff_len();
    hit  = 1'b0;
    ans  = '0;
    if (!hit_done) begin
      if (seen_cnt < MaxHaystackDef) begin
        for (k = MaxNeedleDef - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0]  = b;
        seen_cnt = seen_cnt + 17'd1;
        same = (seen_cnt >= len);
        for (k = 0; k < len; k++) begin
          if (hist[len-1-k] != pat_byte(k)) same = 1'b0;
        end
        if (same) begin
          hit_done   = 1'b1;
          ans.found  = 1'b1;
          // an empty needle always matches at the start
          ans.offset = (len == 0) ? 16'd0 : 16'(seen_cnt - len);
          hit        = 1'b1;
        end
      end else begin
        dropped = 1'b1;
      end
      // no match by the end of the haystack
      if (last && !hit_done) begin
        ans.truncated = dropped;
        hit           = 1'b1;
      end
    end
    if (last) begin
      for (k = 0; k < MaxNeedleDef; k++) hist[k] = '0;
      seen_cnt = '0;
      hit_done = 1'b0;
      dropped  = 1'b0;
    end
    return hit;
  endfunction

  function automatic void log_fault(input string what, input answer_t want,
                                    input answer_t got);
    fail_count++;
    if (fail_count <= MaxReported) begin
      $display("%0t %s: exp found=%0b off=%0d trunc=%0b, got found=%0b off=%0d trunc=%0b",
               $time, what, want.found, want.offset, want.truncated,
               got.found, got.offset, got.truncated);
    end
  endfunction

  // queue one haystack, optionally with the needle planted at a random spot
  function automatic void add_haystack(input int unsigned hs_len, input bit plant);
    int unsigned len;
    int unsigned at;
    int unsigned i;
    logic [7:0]  b;
    len = eff_len();
    at  = (plant && hs_len >= len) ? $urandom_range(hs_len - len) : hs_len;
    for (i = 0; i < hs_len; i++) begin
      if (i >= at && i < at + len) b = pat_byte(i - at);
      else if (len != 0 && $urandom_range(1) == 1) b = pat_byte($urandom_range(len - 1));
      else b = 8'($urandom);
      hay_pending.push_back('{data: b, last: (i == hs_len - 1)});
    end
  endfunction

  // register write, mirrored into the local needle copy
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NEEDLE_LEN: pat_len      = val[LenW-1:0];
      REG_NEEDLE_A:   pat_words[0] = val;
      REG_NEEDLE_B:   pat_words[1] = val;
      REG_NEEDLE_C:   pat_words[2] = val;
      REG_NEEDLE_D:   pat_words[3] = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for every byte taken and every result back, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (hay_pending.size() != 0 || in_valid || answers_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // random needle, then random haystacks totalling about n_items bytes
  task automatic run_random_phase(input logic [LenW-1:0] len, input bit narrow,
                                  input int unsigned idle_pct, input int unsigned n_items);
    logic [CfgDataW-1:0] w;
    int unsigned k;
    int unsigned j;
    int unsigned sent;
    int unsigned hs_len;
    wait_idle();
    write_reg(REG_NEEDLE_LEN, CfgDataW'(len));
    for (k = 0; k < 4; k++) begin
      w = {$urandom, $urandom};
      // two-letter needles give many partial matches
      if (narrow) begin
        for (j = 0; j < 8; j++) w[j*8 +: 8] = 8'h61 + 8'($urandom_range(1));
      end
      write_reg(CfgIdxW'(REG_NEEDLE_A + k), w);
    end
    @(negedge clk);
    src_idle_pct  = idle_pct;
    sink_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      hs_len = ($urandom_range(9) == 0) ? $urandom_range(1, 80)
                                        : $urandom_range(1, eff_len() + 12);
      add_haystack(hs_len, $urandom_range(1) == 1);
      sent += hs_len;
    end
  endtask

  // byte source
  always @(posedge clk) begin : feed
    hay_beat_t beat;
    if (rst_n && (!in_valid || in_ready)) begin
      if (hay_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        beat = hay_pending.pop_front();
        in_valid  <= 1'b1;
        data_byte <= beat.data;
        last_byte <= beat.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and an occasional long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (rx_hold_left != 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_hold_served != rx_hold_reqs) begin
        rx_hold_served++;
        rx_hold_left = RxHoldCycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // predict on each input beat, check each result beat
  always @(posedge clk) begin : watch
    answer_t want;
    answer_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (scan_byte(data_byte, last_byte, want)) answers_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{found: res_found, offset: res_offset, truncated: res_truncated};
        if (answers_due.size() == 0) begin
          log_fault("result with nothing pending", '0, got);
        end else begin
          want = answers_due.pop_front();
          if (got.found !== want.found || got.offset !== want.offset ||
              got.truncated !== want.truncated) begin
            log_fault("result mismatch", want, got);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [LenW-1:0] phase_len [10];
    int unsigned p;
    int s;
    phase_len = '{6'd63, 6'd1, 6'd32, 6'd0, 6'd3, 6'd33, 6'd8, 6'd31, 6'd2, 6'd0};
    phase_len[9] = 6'($urandom_range(63));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty needle straight after reset
    hay_pending.push_back('{data: 8'h00, last: 1'b1});
    wait_idle();

    // three byte needle 41 00 ff, upper words all ones
    write_reg(REG_NEEDLE_LEN, CfgDataW'(3));
    write_reg(REG_NEEDLE_A, 64'hFFFF_FFFF_FFFF_0041);
    write_reg(REG_NEEDLE_B, '1);
    write_reg(REG_NEEDLE_C, '1);
    write_reg(REG_NEEDLE_D, '1);
    // spare indexes must leave the needle alone
    for (s = RegSpareLo; s < 2**CfgIdxW; s++) write_reg(CfgIdxW'(s), '1);
    @(negedge clk);
    // match on the last byte
    hay_pending.push_back('{data: 8'h41, last: 1'b0});
    hay_pending.push_back('{data: 8'h00, last: 1'b0});
    hay_pending.push_back('{data: 8'hFF, last: 1'b1});
    // haystack shorter than the needle
    hay_pending.push_back('{data: 8'h41, last: 1'b0});
    hay_pending.push_back('{data: 8'h00, last: 1'b1});
    // match at offset 1, later bytes and a second match are ignored
    hay_pending.push_back('{data: 8'hFF, last: 1'b0});
    hay_pending.push_back('{data: 8'h41, last: 1'b0});
    hay_pending.push_back('{data: 8'h00, last: 1'b0});
    hay_pending.push_back('{data: 8'hFF, last: 1'b0});
    hay_pending.push_back('{data: 8'h41, last: 1'b0});
    hay_pending.push_back('{data: 8'h00, last: 1'b0});
    hay_pending.push_back('{data: 8'hFF, last: 1'b0});
    hay_pending.push_back('{data: 8'h12, last: 1'b1});
    // needle shortened in the middle of a haystack
    hay_pending.push_back('{data: 8'h10, last: 1'b0});
    hay_pending.push_back('{data: 8'h41, last: 1'b0});
    wait_idle();
    write_reg(REG_NEEDLE_LEN, CfgDataW'(2));
    @(negedge clk);
    hay_pending.push_back('{data: 8'h00, last: 1'b0});
    hay_pending.push_back('{data: 8'h33, last: 1'b1});

    // random phases, one of them without any idling
    for (p = 0; p < 10; p++) begin
      run_random_phase(phase_len[p], p[0], (p == 4) ? 0 : 35, 60);
    end

    // long sink hold-off with the source running flat out
    wait_idle();
    write_reg(REG_NEEDLE_LEN, CfgDataW'(0));
    @(negedge clk);
    src_idle_pct  = 0;
    sink_idle_pct = 35;
    rx_hold_reqs++;
    repeat (60) add_haystack($urandom_range(1, 3), 1'b0);
    wait_idle();
    src_idle_pct = 35;

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
